@@ rtl/calendar_time_advance_top_defines.svh @@
// assertion macros for the calendar time advance block
`ifndef CALENDAR_TIME_ADVANCE_TOP_DEFINES_SVH
`define CALENDAR_TIME_ADVANCE_TOP_DEFINES_SVH

// same-cycle implication
`define CTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cta_pkg.sv @@
// shared types, constants and calendar functions for the calendar time advance block
`timescale 1ns / 1ps

package cta_pkg;

    localparam int STEP_COUNT_BITS_DEF = 32;
    localparam logic [13:0] MAX_YEAR = 14'd9999;

    typedef enum logic [1:0] {
        KIND_ADVANCE,
        KIND_LOAD,
        KIND_REJECT
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_REJECT,
        ST_OVERFLOW,
        ST_UNLOADED
    } t_status;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DMUL,
        B_DREM,
        B_TOD,
        B_TODFIX,
        B_HMUL,
        B_HREM,
        B_HFIX,
        B_MMUL,
        B_MREM,
        B_MFIX,
        B_WALK
    } t_back_state;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] add_seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] steps;
    } t_req;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] step_count;
        t_status     status;
    } t_result;

    // (k * 256) mod 400, period 25 in k
    function automatic logic [8:0] hi256_mod400(input logic [4:0] idx);
        logic [8:0] v;
        unique case (idx)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd256;
            5'd2:    v = 9'd112;
            5'd3:    v = 9'd368;
            5'd4:    v = 9'd224;
            5'd5:    v = 9'd80;
            5'd6:    v = 9'd336;
            5'd7:    v = 9'd192;
            5'd8:    v = 9'd48;
            5'd9:    v = 9'd304;
            5'd10:   v = 9'd160;
            5'd11:   v = 9'd16;
            5'd12:   v = 9'd272;
            5'd13:   v = 9'd128;
            5'd14:   v = 9'd384;
            5'd15:   v = 9'd240;
            5'd16:   v = 9'd96;
            5'd17:   v = 9'd352;
            5'd18:   v = 9'd208;
            5'd19:   v = 9'd64;
            5'd20:   v = 9'd320;
            5'd21:   v = 9'd176;
            5'd22:   v = 9'd32;
            5'd23:   v = 9'd288;
            5'd24:   v = 9'd144;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // gregorian leap test, year split as hi * 256 + lo for the mod 400
    function automatic logic leap_of(input logic [13:0] y, input logic en);
        logic [5:0] hi;
        logic [4:0] idx;
        logic [9:0] sum;
        logic [8:0] r400;
        logic [6:0] r100;
        hi = y[13:8];
        if (hi >= 6'd50) begin
            idx = 5'(hi - 6'd50);
        end else if (hi >= 6'd25) begin
            idx = 5'(hi - 6'd25);
        end else begin
            idx = hi[4:0];
        end
        sum = 10'(hi256_mod400(idx)) + 10'(y[7:0]);
        if (sum >= 10'd400) begin
            r400 = 9'(sum - 10'd400);
        end else begin
            r400 = sum[8:0];
        end
        if (r400 >= 9'd300) begin
            r100 = 7'(r400 - 9'd300);
        end else if (r400 >= 9'd200) begin
            r100 = 7'(r400 - 9'd200);
        end else if (r400 >= 9'd100) begin
            r100 = 7'(r400 - 9'd100);
        end else begin
            r100 = r400[6:0];
        end
        return en && (y[1:0] == 2'd0) && ((r100 != 7'd0) || (r400 == 9'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/cta_fifo2.sv @@
// two-entry queue with head and tail registers
`timescale 1ns / 1ps

module cta_fifo2 #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic             r_v0, r_v1, n_v0, n_v1;
    logic [WIDTH-1:0] r_head, r_tail, n_head, n_tail;
    logic             w_push, w_pop;

    assign w_push  = i_push && !r_v1;
    assign w_pop   = i_pop && r_v0;
    assign o_full  = r_v1;
    assign o_empty = !r_v0;
    assign o_data  = r_head;

    always_comb begin
        n_v0   = r_v0;
        n_v1   = r_v1;
        n_head = r_head;
        n_tail = r_tail;
        if (w_pop) begin
            if (r_v1) begin
                n_head = r_tail;
                if (w_push) begin
                    n_tail = i_data;
                end else begin
                    n_v1 = 1'b0;
                end
            end else if (w_push) begin
                n_head = i_data;
            end else begin
                n_v0 = 1'b0;
            end
        end else if (w_push) begin
            if (!r_v0) begin
                n_head = i_data;
                n_v0   = 1'b1;
            end else begin
                n_tail = i_data;
                n_v1   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

@@ rtl/cta_front.sv @@
// front end: takes requests, checks loads, queues classified requests
`timescale 1ns / 1ps

module cta_front
    import cta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_leap_en,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_req_type,
    input  logic [30:0] i_add_seconds,
    input  logic [13:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [4:0]  i_load_hour,
    input  logic [5:0]  i_load_minute,
    input  logic [5:0]  i_load_second,
    input  logic [31:0] i_load_steps,
    output logic        o_req_valid,
    output t_req        o_req,
    input  logic        i_req_take
);

    t_req       w_req;
    logic       w_valid;
    logic [4:0] w_len;
    logic       w_empty;

    assign w_len = month_len(leap_of(i_load_year, i_leap_en), i_load_month);

    always_comb begin
        w_valid = (i_load_year <= MAX_YEAR)
               && (i_load_month >= 4'd1) && (i_load_month <= 4'd12)
               && (i_load_day >= 5'd1) && (i_load_day <= w_len)
               && (i_load_hour <= 5'd23)
               && (i_load_minute <= 6'd59)
               && (i_load_second <= 6'd59);
        w_req.add_seconds = i_add_seconds;
        w_req.year        = i_load_year;
        w_req.month       = i_load_month;
        w_req.day         = i_load_day;
        w_req.hour        = i_load_hour;
        w_req.minute      = i_load_minute;
        w_req.second      = i_load_second;
        w_req.steps       = i_load_steps;
        if (!i_req_type) begin
            w_req.kind = KIND_ADVANCE;
        end else if (w_valid) begin
            w_req.kind = KIND_LOAD;
        end else begin
            w_req.kind = KIND_REJECT;
        end
    end

    cta_fifo2 #(
        .WIDTH($bits(t_req))
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_req),
        .o_full  (o_full),
        .i_pop   (i_req_take),
        .o_empty (w_empty),
        .o_data  (o_req)
    );

    assign o_req_valid = !w_empty;

endmodule

@@ rtl/cta_back.sv @@
// back end: calendar state and the sequenced advance datapath
`timescale 1ns / 1ps

module cta_back
    import cta_pkg::*;
#(
    parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_leap_en,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_req_take,
    input  logic    i_out_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam logic [22:0] DAY_RECIP = 23'd6362914;  // floor(2^32 / 675)
    localparam logic [9:0]  DAY_HI    = 10'd675;      // 86400 / 128
    localparam logic [16:0] SECS_DAY  = 17'd86400;
    localparam logic [12:0] HR_RECIP  = 13'd4660;     // floor(2^24 / 3600)
    localparam logic [11:0] SECS_HR   = 12'd3600;
    localparam logic [12:0] MIN_RECIP = 13'd4369;     // floor(2^18 / 60)
    localparam logic [5:0]  SECS_MIN  = 6'd60;

    t_back_state r_state, n_state;

    // architectural state
    logic                       r_loaded, n_loaded;
    logic [13:0]                r_year, n_year;
    logic [3:0]                 r_month, n_month;
    logic [4:0]                 r_day, n_day;
    logic [4:0]                 r_hour, n_hour;
    logic [5:0]                 r_minute, n_minute;
    logic [5:0]                 r_second, n_second;
    logic [STEP_COUNT_BITS-1:0] r_steps, n_steps;

    // working registers
    logic [30:0] r_add, n_add;
    logic [14:0] r_q, n_q;
    logic [10:0] r_rem, n_rem;
    logic [17:0] r_tod, n_tod;
    logic [15:0] r_dd, n_dd;
    logic [3:0]  r_mm, n_mm;
    logic [13:0] r_yy, n_yy;
    logic [4:0]  r_hq, n_hq;
    logic [12:0] r_hrem, n_hrem;
    logic [4:0]  r_hr, n_hr;
    logic [11:0] r_mrem, n_mrem;
    logic [5:0]  r_mq, n_mq;
    logic [6:0]  r_srem, n_srem;
    logic [5:0]  r_mi, n_mi;
    logic [5:0]  r_se, n_se;

    t_status     w_status;
    logic [46:0] w_prod_d;
    logic [24:0] w_rem_d;
    logic [14:0] w_q_fix;
    logic [10:0] w_rem_fix;
    logic [17:0] w_tod_sum;
    logic [29:0] w_prod_h;
    logic [16:0] w_hrem;
    logic [24:0] w_prod_m;
    logic [11:0] w_srem;
    logic [4:0]  w_len;
    logic [63:0] w_ld_wide;
    logic [63:0] w_steps_wide;

    assign w_prod_d  = 47'(r_add[30:7]) * 47'(DAY_RECIP);
    assign w_rem_d   = 25'(r_add[30:7]) - 25'(r_q) * 25'(DAY_HI);
    assign w_q_fix   = r_q + 15'(r_rem >= 11'(DAY_HI));
    assign w_rem_fix = (r_rem >= 11'(DAY_HI)) ? (r_rem - 11'(DAY_HI)) : r_rem;
    assign w_tod_sum = 18'(r_hour) * 18'(SECS_HR) + 18'(r_minute) * 18'(SECS_MIN)
                     + 18'(r_second) + 18'({w_rem_fix[9:0], r_add[6:0]});
    assign w_prod_h  = 30'(r_tod[16:0]) * 30'(HR_RECIP);
    assign w_hrem    = r_tod[16:0] - 17'(r_hq) * 17'(SECS_HR);
    assign w_prod_m  = 25'(r_mrem) * 25'(MIN_RECIP);
    assign w_srem    = r_mrem - 12'(r_mq) * 12'(SECS_MIN);
    assign w_len     = month_len(leap_of(r_yy, i_leap_en), r_mm);
    assign w_ld_wide = 64'(i_req.steps);

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_second   = r_second;
        n_steps    = r_steps;
        n_add      = r_add;
        n_q        = r_q;
        n_rem      = r_rem;
        n_tod      = r_tod;
        n_dd       = r_dd;
        n_mm       = r_mm;
        n_yy       = r_yy;
        n_hq       = r_hq;
        n_hrem     = r_hrem;
        n_hr       = r_hr;
        n_mrem     = r_mrem;
        n_mq       = r_mq;
        n_srem     = r_srem;
        n_mi       = r_mi;
        n_se       = r_se;
        o_req_take = 1'b0;
        o_res_push = 1'b0;
        w_status   = ST_OK;
        unique case (r_state)
            B_IDLE: begin
                if (i_req_valid && !i_out_full) begin
                    o_req_take = 1'b1;
                    unique case (i_req.kind)
                        KIND_LOAD: begin
                            n_year     = i_req.year;
                            n_month    = i_req.month;
                            n_day      = i_req.day;
                            n_hour     = i_req.hour;
                            n_minute   = i_req.minute;
                            n_second   = i_req.second;
                            n_steps    = w_ld_wide[STEP_COUNT_BITS-1:0];
                            n_loaded   = 1'b1;
                            o_res_push = 1'b1;
                        end
                        KIND_ADVANCE: begin
                            if (!r_loaded) begin
                                w_status   = ST_UNLOADED;
                                o_res_push = 1'b1;
                            end else begin
                                n_add   = i_req.add_seconds;
                                n_mm    = r_month;
                                n_yy    = r_year;
                                n_state = B_DMUL;
                            end
                        end
                        default: begin
                            w_status   = ST_REJECT;
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            B_DMUL: begin
                n_q     = w_prod_d[46:32];
                n_state = B_DREM;
            end
            B_DREM: begin
                n_rem   = w_rem_d[10:0];
                n_state = B_TOD;
            end
            B_TOD: begin
                n_tod   = w_tod_sum;
                n_dd    = 16'(r_day) + 16'(w_q_fix);
                n_state = B_TODFIX;
            end
            B_TODFIX: begin
                if (r_tod >= 18'(SECS_DAY)) begin
                    n_tod = r_tod - 18'(SECS_DAY);
                    n_dd  = r_dd + 16'd1;
                end
                n_state = B_HMUL;
            end
            B_HMUL: begin
                n_hq    = w_prod_h[28:24];
                n_state = B_HREM;
            end
            B_HREM: begin
                n_hrem  = w_hrem[12:0];
                n_state = B_HFIX;
            end
            B_HFIX: begin
                if (r_hrem >= 13'(SECS_HR)) begin
                    n_hr   = r_hq + 5'd1;
                    n_mrem = 12'(r_hrem - 13'(SECS_HR));
                end else begin
                    n_hr   = r_hq;
                    n_mrem = r_hrem[11:0];
                end
                n_state = B_MMUL;
            end
            B_MMUL: begin
                n_mq    = w_prod_m[23:18];
                n_state = B_MREM;
            end
            B_MREM: begin
                n_srem  = w_srem[6:0];
                n_state = B_MFIX;
            end
            B_MFIX: begin
                if (r_srem >= 7'(SECS_MIN)) begin
                    n_mi = r_mq + 6'd1;
                    n_se = 6'(r_srem - 7'(SECS_MIN));
                end else begin
                    n_mi = r_mq;
                    n_se = r_srem[5:0];
                end
                n_state = B_WALK;
            end
            B_WALK: begin
                if (r_dd > 16'(w_len)) begin
                    n_dd = r_dd - 16'(w_len);
                    if (r_mm == 4'd12) begin
                        if (r_yy == MAX_YEAR) begin
                            w_status   = ST_OVERFLOW;
                            o_res_push = 1'b1;
                            n_state    = B_IDLE;
                        end else begin
                            n_mm = 4'd1;
                            n_yy = r_yy + 14'd1;
                        end
                    end else begin
                        n_mm = r_mm + 4'd1;
                    end
                end else begin
                    n_year     = r_yy;
                    n_month    = r_mm;
                    n_day      = r_dd[4:0];
                    n_hour     = r_hr;
                    n_minute   = r_mi;
                    n_second   = r_se;
                    n_steps    = r_steps + STEP_COUNT_BITS'(1);
                    o_res_push = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign w_steps_wide = 64'(n_steps);

    always_comb begin
        o_res.year       = n_year;
        o_res.month      = n_month;
        o_res.day        = n_day;
        o_res.hour       = n_hour;
        o_res.minute     = n_minute;
        o_res.second     = n_second;
        o_res.step_count = w_steps_wide[31:0];
        o_res.status     = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_year   <= 14'd0;
            r_month  <= 4'd1;
            r_day    <= 5'd1;
            r_hour   <= 5'd0;
            r_minute <= 6'd0;
            r_second <= 6'd0;
            r_steps  <= '0;
        end else begin
            r_loaded <= n_loaded;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_steps  <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_add  <= n_add;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_tod  <= n_tod;
        r_dd   <= n_dd;
        r_mm   <= n_mm;
        r_yy   <= n_yy;
        r_hq   <= n_hq;
        r_hrem <= n_hrem;
        r_hr   <= n_hr;
        r_mrem <= n_mrem;
        r_mq   <= n_mq;
        r_srem <= n_srem;
        r_mi   <= n_mi;
        r_se   <= n_se;
    end

endmodule

@@ rtl/calendar_time_advance_top.sv @@
// top level of the calendar time advance block
//
//  channel   direction  handshake             payload
//  request   in         push / full           i_req_type, i_add_seconds, i_load_*
//  result    out        empty / pop           o_year .. o_second, o_step_count, o_status
//  config    in         i_cfg_we              i_cfg_wdata (leap enable)
//
//  load, rejected load or advance before load: registered in the request queue, then
//    answered by the idle back end straight into the result queue
//  advance: the sequenced divide steps and then the one-month-a-cycle walk in the back end
//  the back end works one request at a time; two-entry queues on each side
//  synchronous active-low reset clears both queues and the calendar state
//  a full result queue holds the back end before it takes the next request
`timescale 1ns / 1ps

module calendar_time_advance_top
    import cta_pkg::*;
#(
    parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [30:0] i_add_seconds,
    input  logic [13:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [4:0]  i_load_hour,
    input  logic [5:0]  i_load_minute,
    input  logic [5:0]  i_load_second,
    input  logic [31:0] i_load_steps,
    output logic        empty,
    input  logic        pop,
    output logic [13:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [31:0] o_step_count,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic    r_leap_en, n_leap_en;
    logic    w_req_valid;
    t_req    w_req;
    logic    w_req_take;
    logic    w_out_full;
    logic    w_res_push;
    t_result w_res;
    t_result w_res_q;

    assign n_leap_en = i_cfg_we ? i_cfg_wdata : r_leap_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leap_en <= 1'b1;
        end else begin
            r_leap_en <= n_leap_en;
        end
    end

    cta_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_leap_en     (r_leap_en),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_add_seconds (i_add_seconds),
        .i_load_year   (i_load_year),
        .i_load_month  (i_load_month),
        .i_load_day    (i_load_day),
        .i_load_hour   (i_load_hour),
        .i_load_minute (i_load_minute),
        .i_load_second (i_load_second),
        .i_load_steps  (i_load_steps),
        .o_req_valid   (w_req_valid),
        .o_req         (w_req),
        .i_req_take    (w_req_take)
    );

    cta_back #(
        .STEP_COUNT_BITS(STEP_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_leap_en   (r_leap_en),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_take  (w_req_take),
        .i_out_full  (w_out_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    cta_fifo2 #(
        .WIDTH($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_q)
    );

    assign o_year       = w_res_q.year;
    assign o_month      = w_res_q.month;
    assign o_day        = w_res_q.day;
    assign o_hour       = w_res_q.hour;
    assign o_minute     = w_res_q.minute;
    assign o_second     = w_res_q.second;
    assign o_step_count = w_res_q.step_count;
    assign o_status     = w_res_q.status;

endmodule

@@ rtl/cta_checker.sv @@
// port-level checks for the calendar time advance block, bound to the top level
`timescale 1ns / 1ps
`include "calendar_time_advance_top_defines.svh"

module cta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [13:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second,
    input logic [31:0] o_step_count,
    input logic [1:0]  o_status
);

    // calendar fields of any result stay in range
    `CTA_ASSERT_IMP(a_fields_in_range, i_clk, i_rst_n, !empty, (o_year <= 14'd9999) && (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day >= 5'd1) && (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59), "result field out of range")

    // not-loaded results carry the reset timestamp
    `CTA_ASSERT_IMP(a_unloaded_is_reset, i_clk, i_rst_n, !empty && (o_status == 2'd3), (o_year == 14'd0) && (o_month == 4'd1) && (o_day == 5'd1) && (o_hour == 5'd0) && (o_minute == 6'd0) && (o_second == 6'd0) && (o_step_count == 32'd0), "not-loaded result without reset state")

    // days beyond 29 only in a month long enough
    `CTA_ASSERT_IMP(a_day_vs_month, i_clk, i_rst_n, !empty && (o_day > 5'd29), (o_month != 4'd2) && ((o_day != 5'd31) || (o_month == 4'd1) || (o_month == 4'd3) || (o_month == 4'd5) || (o_month == 4'd7) || (o_month == 4'd8) || (o_month == 4'd10) || (o_month == 4'd12)), "day exceeds month length")

    // a waiting result holds until popped
    `CTA_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_year) && $stable(o_day) && $stable(o_step_count) && $stable(o_status), "waiting result changed")

endmodule

bind calendar_time_advance_top cta_checker u_cta_checker (.*);
